>>> design/hlca_pkg.sv
package hlca_pkg;

   localparam int FRAC_BITS = 12;
   localparam int ONE       = 1 << FRAC_BITS;
   localparam int LMIN      = (ONE + 50) / 100;
   localparam int LMAX      = (99 * ONE + 50) / 100;
   localparam int THIRD     = (ONE + 1) / 3;

   localparam int GAIN_W   = 15;
   localparam int OFFS_W   = 14;
   localparam int CSR_W    = 15;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_CONTRAST_GAIN     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTNESS_OFFSET = 1'd1;

   localparam logic signed [GAIN_W-1:0] GAIN_RESET = 15'sd4096;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [7:0] alpha_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic [7:0] alpha_out;
   } rsp_type;

endpackage

>>> design/hsl_lightness_contrast_adjust.sv
// Channel | Ports                          | Direction
// req     | req_valid, req_ready, req_data | in  (RGBA8 pixel)
// rsp     | rsp_valid, rsp_ready, rsp_data | out (adjusted RGBA8 pixel)
// csr     | csr_we, csr_index, csr_wdata   | in  (gain, offset)
// One pixel per clock while rsp is not stalled.
// Lightness (sum*ONE/510) is a shift-and-add reciprocal in stage two; the
// saturation and hue divisions are restoring dividers split over stages 3..5.
// Reset clears all valid bits and sets gain to unity and offset to zero.
// A stall on rsp freezes every stage at once; nothing is lost or repeated.
module hsl_lightness_contrast_adjust (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  hlca_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output hlca_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [hlca_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [hlca_pkg::CSR_W-1:0]           csr_wdata
);

   localparam int F   = hlca_pkg::FRAC_BITS;
   localparam int NS  = 8;
   localparam int QW  = F + 1;

   // configuration registers
   logic signed [hlca_pkg::GAIN_W-1:0] gain_ff;
   logic signed [hlca_pkg::OFFS_W-1:0] offs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= hlca_pkg::GAIN_RESET;
         offs_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            hlca_pkg::CSR_CONTRAST_GAIN:
               gain_ff <= csr_wdata[hlca_pkg::GAIN_W-1:0];
            hlca_pkg::CSR_BRIGHTNESS_OFFSET:
               offs_ff <= csr_wdata[hlca_pkg::OFFS_W-1:0];
            default: ;
         endcase
      end
   end

   // global enable: whole pipe advances unless the output is held
   logic advance;
   logic [NS-1:0] vld_ff;
   assign advance   = !vld_ff[NS-1] || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[NS-2:0], req_valid};
   end

   // stage 1: max, min, hue numerator
   logic [7:0]  s1_mx_in, s1_mn_in;
   logic [10:0] s1_num_in;
   always_comb begin
      logic [7:0] r, g, b;
      r = req_data.red_in; g = req_data.green_in; b = req_data.blue_in;
      s1_mx_in = r; s1_mn_in = r;
      if (g > s1_mx_in) s1_mx_in = g;
      if (b > s1_mx_in) s1_mx_in = b;
      if (g < s1_mn_in) s1_mn_in = g;
      if (b < s1_mn_in) s1_mn_in = b;
      if (s1_mx_in == r)
         s1_num_in = (g >= b) ? 11'(g - b)
                              : 11'(11'(g) + 11'(6 * (s1_mx_in - s1_mn_in)) - 11'(b));
      else if (s1_mx_in == g)
         s1_num_in = 11'(11'(b) + 11'(2 * (s1_mx_in - s1_mn_in)) - 11'(r));
      else
         s1_num_in = 11'(11'(r) + 11'(4 * (s1_mx_in - s1_mn_in)) - 11'(g));
   end

   logic [7:0]  s1_d_ff;
   logic [8:0]  s1_sum_ff;
   logic [10:0] s1_num_ff;
   logic [7:0]  s1_a_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_d_ff   <= s1_mx_in - s1_mn_in;
         s1_sum_ff <= 9'(s1_mx_in) + 9'(s1_mn_in);
         s1_num_ff <= s1_num_in;
         s1_a_ff   <= req_data.alpha_in;
      end
   end

   // stage 2: lightness, and the dividends and divisors for S and H
   // sum*ONE/510 = y + y/255 with y = sum << (F-9); y/255 = (y+1+(y>>8))>>8
   // numerators: S: d*ONE/den, H: num*ONE/(6d)
   localparam int DW = 11 + F;
   logic [F-1:0]  s2_y_in;
   logic [QW-1:0] s2_l_in;
   always_comb begin
      s2_y_in = F'(s1_sum_ff) << (F - 9);
      s2_l_in = QW'(s2_y_in)
              + ((QW'(s2_y_in) + QW'(1) + QW'(s2_y_in >> 8)) >> 8);
   end

   logic [QW-1:0] s2_l_ff;
   logic [DW-1:0] s2_sn_ff, s2_hn_ff;
   logic [10:0]   s2_sd_ff, s2_hd_ff;
   logic [7:0]    s2_d_ff, s2_a_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         s2_l_ff  <= s2_l_in;
         s2_sn_ff <= DW'(s1_d_ff) << F;
         s2_hn_ff <= DW'(s1_num_ff) << F;
         s2_sd_ff <= (s1_sum_ff > 9'd255) ? 11'(10'd510 - 10'(s1_sum_ff))
                                          : 11'(s1_sum_ff);
         s2_hd_ff <= 11'(6 * s1_d_ff);
         s2_d_ff  <= s1_d_ff;
         s2_a_ff  <= s1_a_ff;
      end
   end

   // stages 3..5: restoring division, quotient bits split over three stages
   // Each quotient fits QW bits (all values stay at or below ONE).
   localparam int B1 = (QW + 2) / 3;
   localparam int B2 = (QW + 1) / 3;
   localparam int B3 = QW - B1 - B2;

   typedef struct packed {
      logic [DW-1:0] sn, hn;
      logic [QW-1:0] lq, sq, hq;
      logic [10:0]   sd, hd;
      logic [7:0]    d, a;
   } div_type;

   function automatic div_type div_bits(input div_type x, input int hi, input int cnt);
      div_type y;
      logic [DW+QW-1:0] t;
      y = x;
      for (int k = 0; k < cnt; k++) begin
         t = (DW+QW)'(y.sd) << (hi - k);
         if (y.sd != 0 && (DW+QW)'(y.sn) >= t) begin
            y.sn = DW'((DW+QW)'(y.sn) - t); y.sq[hi-k] = 1'b1;
         end
         t = (DW+QW)'(y.hd) << (hi - k);
         if (y.hd != 0 && (DW+QW)'(y.hn) >= t) begin
            y.hn = DW'((DW+QW)'(y.hn) - t); y.hq[hi-k] = 1'b1;
         end
      end
      return y;
   endfunction

   div_type s3_in, s3_ff, s4_ff, s5_ff;
   always_comb begin
      s3_in    = '0;
      s3_in.lq = s2_l_ff;
      s3_in.sn = s2_sn_ff; s3_in.hn = s2_hn_ff;
      s3_in.sd = s2_sd_ff; s3_in.hd = s2_hd_ff;
      s3_in.d  = s2_d_ff;  s3_in.a  = s2_a_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_ff <= div_bits(s3_in, QW - 1, B1);
         s4_ff <= div_bits(s3_ff, QW - 1 - B1, B2);
         s5_ff <= div_bits(s4_ff, QW - 1 - B1 - B2, B3);
      end
   end

   // stage 6: lightness gain, offset, clamp; gray flag
   localparam int LW = F + 2;
   logic signed [LW-1:0] s6_l_in;
   always_comb begin
      logic signed [QW+hlca_pkg::GAIN_W:0] prod;
      logic signed [QW+hlca_pkg::GAIN_W+1:0] adj;
      prod = $signed({1'b0, s5_ff.lq}) * gain_ff;
      adj  = (QW+hlca_pkg::GAIN_W+2)'(prod >>> F) + (QW+hlca_pkg::GAIN_W+2)'(offs_ff);
      if (adj > hlca_pkg::LMAX)      s6_l_in = LW'(hlca_pkg::LMAX);
      else if (adj < hlca_pkg::LMIN) s6_l_in = LW'(hlca_pkg::LMIN);
      else                           s6_l_in = LW'(adj);
   end

   logic signed [LW-1:0] s6_l_ff;
   logic [QW-1:0] s6_s_ff, s6_h_ff;
   logic          s6_gray_ff;
   logic [7:0]    s6_a_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         s6_l_ff    <= s6_l_in;
         s6_s_ff    <= s5_ff.sq;
         s6_h_ff    <= s5_ff.hq;
         s6_gray_ff <= (s5_ff.d == 8'd0) || (s5_ff.sq == '0);
         s6_a_ff    <= s5_ff.a;
      end
   end

   // stage 7: q, p and the three hue phases
   localparam int PW = F + 3;
   logic signed [PW-1:0] s7_q_in;
   always_comb begin
      logic [2*QW+1:0] m;
      if (2 * s6_l_ff < hlca_pkg::ONE) begin
         m = (2*QW+2)'(s6_l_ff) * ((2*QW+2)'(hlca_pkg::ONE) + (2*QW+2)'(s6_s_ff));
         s7_q_in = PW'(m >> F);
      end else begin
         m = (2*QW+2)'(s6_l_ff) * (2*QW+2)'(s6_s_ff);
         s7_q_in = PW'(PW'(s6_l_ff) + PW'(s6_s_ff) - PW'(m >> F));
      end
   end

   logic signed [PW-1:0] s7_p_ff, s7_q_ff, s7_l_ff;
   logic [F-1:0]  s7_t_ff [3];
   logic          s7_gray_ff;
   logic [7:0]    s7_a_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         s7_q_ff    <= s7_q_in;
         s7_p_ff    <= PW'(2 * PW'(s6_l_ff)) - s7_q_in;
         s7_l_ff    <= PW'(s6_l_ff);
         s7_t_ff[0] <= F'(QW'(s6_h_ff) + QW'(hlca_pkg::THIRD));
         s7_t_ff[1] <= F'(s6_h_ff);
         s7_t_ff[2] <= F'(QW'(s6_h_ff) - QW'(hlca_pkg::THIRD) + QW'(hlca_pkg::ONE));
         s7_gray_ff <= s6_gray_ff;
         s7_a_ff    <= s6_a_ff;
      end
   end

   // stage 8: hue bands and byte conversion
   function automatic logic [7:0] to_byte(input logic signed [PW+1:0] v);
      logic [PW+9:0] c;
      if (v <= 0) return 8'd0;
      c = ((PW+10)'(v) * (PW+10)'(255)) >> F;
      return (c > 255) ? 8'd255 : c[7:0];
   endfunction

   function automatic logic signed [PW+1:0] hue_ch(input logic signed [PW-1:0] p,
         input logic signed [PW-1:0] q, input logic [F-1:0] t);
      logic signed [2*PW+4:0] w;
      logic signed [2*PW+4:0] f;
      w = (2*PW+5)'(q) - (2*PW+5)'(p);
      if (6 * (F+3)'(t) < hlca_pkg::ONE) begin
         w = w * (2*PW+5)'(6 * (F+3)'(t));
      end else if (2 * (F+1)'(t) < hlca_pkg::ONE) begin
         return (PW+2)'(q);
      end else if (3 * (F+2)'(t) < 2 * hlca_pkg::ONE) begin
         w = w * ((2*PW+5)'(4 * hlca_pkg::ONE) - (2*PW+5)'(6 * (F+3)'(t)));
      end else begin
         return (PW+2)'(p);
      end
      f = w >>> F;
      return (PW+2)'((2*PW+5)'(p) + f);
   endfunction

   hlca_pkg::rsp_type s8_in, s8_ff;
   always_comb begin
      s8_in.alpha_out = s7_a_ff;
      if (s7_gray_ff) begin
         s8_in.red_out   = to_byte((PW+2)'(s7_l_ff));
         s8_in.green_out = s8_in.red_out;
         s8_in.blue_out  = s8_in.red_out;
      end else begin
         s8_in.red_out   = to_byte(hue_ch(s7_p_ff, s7_q_ff, s7_t_ff[0]));
         s8_in.green_out = to_byte(hue_ch(s7_p_ff, s7_q_ff, s7_t_ff[1]));
         s8_in.blue_out  = to_byte(hue_ch(s7_p_ff, s7_q_ff, s7_t_ff[2]));
      end
   end

   always_ff @(posedge clock) begin
      if (advance) s8_ff <= s8_in;
   end

   assign rsp_valid = vld_ff[NS-1];
   assign rsp_data  = s8_ff;

`ifndef SYNTHESIS
   a_ready_follows_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready) else $error("ready while held");
   a_hold_keeps_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_data) && rsp_valid)
      else $error("held item changed");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0]) else $error("item lost at entry");
   a_gray_equal: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NS-2] && advance && s7_gray_ff) |=>
      (rsp_data.red_out == rsp_data.green_out && rsp_data.green_out == rsp_data.blue_out))
      else $error("gray pixel channels differ");
`endif

endmodule
